// ===== rtl/bls_pkg.sv =====
package bls_pkg;

  localparam int KIND_W       = 3;
  localparam int KEY_W        = 64;
  localparam int CAP_W        = 6;
  localparam int DEPTH_DEF    = 32;
  localparam int KEY_BITS_DEF = 64;

  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

  // operation codes carried by in_kind
  localparam logic [KIND_W-1:0] KIND_PUSH    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POP     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DUMP_TD = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DUMP_BU = 3'd4;

  // depth of the command queue and of the result queue
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_LVL_W = 3;

  typedef struct packed {
    logic               full;
    logic               empty;
    logic [Q_LVL_W-1:0] level;
  } q_stat_t;

endpackage

// ===== rtl/bls_fifo.sv =====
module bls_fifo
  import bls_pkg::*;
#(
  parameter int WIDTH = KIND_W + KEY_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output q_stat_t          stat
);

  logic [WIDTH-1:0]   q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_LVL_W-1:0] level_r;
  logic               do_wr;
  logic               do_rd;

  assign stat.full  = (level_r == Q_LVL_W'(Q_DEPTH));
  assign stat.empty = (level_r == '0);
  assign stat.level = level_r;

  assign do_wr   = wr_en && !stat.full;
  assign do_rd   = rd_en && !stat.empty;
  assign rd_data = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        level_r <= level_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        level_r <= level_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/bls_front.sv =====
module bls_front
  import bls_pkg::*;
#(
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                         push,
  input  logic [KIND_W-1:0]            in_kind,
  input  logic [KEY_W-1:0]             in_key,
  input  q_stat_t                      cmd_stat,
  output logic                         full,
  output logic                         cmd_we,
  output logic [KIND_W+KEY_BITS-1:0]   cmd_data
);

  logic kind_ok;

  // classify: drop unused codes here so the back never sees them
  always_comb begin
    unique case (in_kind)
      KIND_PUSH, KIND_POP, KIND_PEEK, KIND_DUMP_TD, KIND_DUMP_BU: kind_ok = 1'b1;
      default:                                                    kind_ok = 1'b0;
    endcase
  end

  assign full     = cmd_stat.full;
  assign cmd_we   = push && !cmd_stat.full && kind_ok;
  assign cmd_data = {in_kind, in_key[KEY_BITS-1:0]};

endmodule

// ===== rtl/bls_back.sv =====
module bls_back
  import bls_pkg::*;
#(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [CAP_W-1:0]           cap,
  input  logic [KIND_W+KEY_BITS-1:0] cmd_data,
  input  q_stat_t                    cmd_stat,
  output logic                       cmd_pop,
  input  q_stat_t                    res_stat,
  output logic                       res_we,
  output logic [KEY_BITS:0]          res_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = 7;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic [KEY_BITS-1:0] mem [DEPTH];

  logic                state_r,  state_nxt;
  logic [CW-1:0]       count_r,  count_nxt;
  logic [AW-1:0]       idx_r,    idx_nxt;
  logic [CW-1:0]       left_r,   left_nxt;
  logic                down_r,   down_nxt;
  logic                rd_v_r;
  logic [KEY_BITS-1:0] rd_q_r;
  logic                rd_last_r;

  logic [KIND_W-1:0]   cmd_kind;
  logic [KEY_BITS-1:0] cmd_key;
  logic [CW-1:0]       count_m1;
  logic                room;
  logic                wr_en;
  logic                issue;

  assign cmd_kind = cmd_data[KIND_W+KEY_BITS-1 -: KIND_W];
  assign cmd_key  = cmd_data[KEY_BITS-1:0];
  assign count_m1 = count_r - 1'b1;
  assign room     = (EW'(count_r) < EW'(cap)) && (EW'(count_r) < EW'(DEPTH));

  assign cmd_pop  = (state_r == ST_IDLE) && !cmd_stat.empty;

  // issue a read only when the result queue has a slot for it and the one in flight
  assign issue = (state_r == ST_WALK) &&
                 (({1'b0, res_stat.level} + (Q_LVL_W+1)'(rd_v_r)) < (Q_LVL_W+1)'(Q_DEPTH));

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    left_nxt  = left_r;
    down_nxt  = down_r;
    wr_en     = 1'b0;
    if (cmd_pop) begin
      unique case (cmd_kind)
        KIND_PUSH: begin
          if (room) begin
            wr_en     = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        KIND_POP: begin
          if (count_r != '0) begin
            count_nxt = count_m1;
          end
        end
        KIND_PEEK: begin
          if (count_r != '0) begin
            state_nxt = ST_WALK;
            idx_nxt   = count_m1[AW-1:0];
            left_nxt  = CW'(1);
            down_nxt  = 1'b1;
          end
        end
        KIND_DUMP_TD: begin
          if (count_r != '0) begin
            state_nxt = ST_WALK;
            idx_nxt   = count_m1[AW-1:0];
            left_nxt  = count_r;
            down_nxt  = 1'b1;
          end
        end
        KIND_DUMP_BU: begin
          if (count_r != '0) begin
            state_nxt = ST_WALK;
            idx_nxt   = '0;
            left_nxt  = count_r;
            down_nxt  = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end else if (issue) begin
      idx_nxt  = down_r ? (idx_r - 1'b1) : (idx_r + 1'b1);
      left_nxt = left_r - 1'b1;
      if (left_r == CW'(1)) begin
        state_nxt = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[AW-1:0]] <= cmd_key;
    end
    if (issue) begin
      rd_q_r    <= mem[idx_r];
      rd_last_r <= (left_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    left_r <= left_nxt;
    down_r <= down_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      rd_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rd_v_r  <= issue;
    end
  end

  assign res_we   = rd_v_r;
  assign res_data = {rd_last_r, rd_q_r};

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> !res_stat.full)
    else $error("result written into a full queue");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |=> (count_r == $past(count_r)))
    else $error("stack depth changed during a walk");

  a_walk_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (left_r != '0) && (left_r <= count_r))
    else $error("walk counter out of range");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    EW'(count_r) <= EW'(DEPTH))
    else $error("stack depth above DEPTH");

endmodule

// ===== rtl/bounded_lifo_stack_with_dump.sv =====
// Bounded LIFO stack of key words with peek and full dump. Each transaction on the input
// queue carries one operation: push, pop, peek, dump top-down or dump bottom-up. Push and
// pop give no result; peek gives the top key, each dump gives every stored key with last
// set on the final one; an empty stack, a full stack on push and unused codes give
// nothing. A front stage takes the transaction into a four-entry command queue; the back
// sequencer pulls one command per cycle when idle. Peek and dump walk the entries through
// the single read port of the entry memory, pausing while the result queue has no slot;
// results pass through a four-entry result queue, so input is taken while results wait.
// Capacity (cfg_data) is clamped to DEPTH; lowering it below the stored count keeps the
// entries and only blocks pushes. Entries need no clearing at reset: only entries below
// the count are ever read. Write capacity only while idle.
module bounded_lifo_stack_with_dump
  import bls_pkg::*;
#(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [KEY_W-1:0]  in_key,
  output logic              empty,
  input  logic              pop,
  output logic [KEY_W-1:0]  out_value,
  output logic              out_last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CAP_W-1:0]  cfg_data
);

  localparam int CMD_W = KIND_W + KEY_BITS;

  logic [CAP_W-1:0]  cap_r;
  logic              cmd_we;
  logic [CMD_W-1:0]  cmd_wdata;
  logic [CMD_W-1:0]  cmd_rdata;
  logic              cmd_pop;
  q_stat_t           cmd_stat;
  logic              res_we;
  logic [KEY_BITS:0] res_wdata;
  logic [KEY_BITS:0] res_rdata;
  q_stat_t           res_stat;

  // capacity register: always ready, hold until the next write
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  // front: take the transaction, drop unused codes, trim the key
  bls_front #(
    .KEY_BITS (KEY_BITS)
  ) u_front (
    .push     (push),
    .in_kind  (in_kind),
    .in_key   (in_key),
    .cmd_stat (cmd_stat),
    .full     (full),
    .cmd_we   (cmd_we),
    .cmd_data (cmd_wdata)
  );

  // command queue decouples input acceptance from execution
  bls_fifo #(
    .WIDTH (CMD_W)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_we),
    .wr_data (cmd_wdata),
    .rd_en   (cmd_pop),
    .rd_data (cmd_rdata),
    .stat    (cmd_stat)
  );

  // back: owns the entries and the count, walks them for peek and dump
  bls_back #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cap      (cap_r),
    .cmd_data (cmd_rdata),
    .cmd_stat (cmd_stat),
    .cmd_pop  (cmd_pop),
    .res_stat (res_stat),
    .res_we   (res_we),
    .res_data (res_wdata)
  );

  // result queue: the oldest result sits on the output ports while not empty
  bls_fifo #(
    .WIDTH (KEY_BITS + 1)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_we),
    .wr_data (res_wdata),
    .rd_en   (pop),
    .rd_data (res_rdata),
    .stat    (res_stat)
  );

  assign empty     = res_stat.empty;
  assign out_value = KEY_W'(res_rdata[KEY_BITS-1:0]);
  assign out_last  = res_rdata[KEY_BITS];

endmodule

// ===== tb/tb_bounded_lifo_stack_with_dump.sv =====
`timescale 1ns / 1ps

module tb_bounded_lifo_stack_with_dump
  import bls_pkg::*;
();

  // Codes the block must ignore: no result and no change to the stack.
  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS_DEF);

  localparam int SETTLE_CYCLES = 16;    // command queue plus sequencer, with margin
  localparam int TAIL_CYCLES   = 50;
  localparam int STALL_LIMIT   = 4000;  // cycles with no transaction on any channel
  localparam int RAND_PHASES   = 9;
  localparam int PHASE_ITEMS   = 45;
  localparam int PRINT_LIMIT   = 40;
  localparam int SCRIPT_LEN    = 30;

  typedef struct packed {
    logic [KEY_W-1:0] value;
    logic             last;
  } stack_word_t;

  // How a scripted row is checked: against the predictor, as a silent
  // operation, against one typed-in word, or as a capacity write.
  typedef enum logic [1:0] {ROW_MODEL, ROW_SILENT, ROW_SINGLE, ROW_SETCAP} row_tag_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    row_tag_t          tag;
    logic [KEY_W-1:0]  exp_value;
    logic              exp_last;
  } row_t;

  typedef enum int {IDLE_RECV_SLOW, IDLE_SEND_SLOW, IDLE_NONE} idle_mode_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              push      = 1'b0;
  logic              full;
  logic [KIND_W-1:0] in_kind   = KIND_PUSH;
  logic [KEY_W-1:0]  in_key    = '0;
  logic              empty;
  logic              pop       = 1'b0;
  logic [KEY_W-1:0]  out_value;
  logic              out_last;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CAP_W-1:0]  cfg_data  = CAP_RESET;

  // Predictor state: stored keys (index 0 is the bottom), fill level, capacity.
  logic [KEY_W-1:0] model_entries [DEPTH_DEF];
  int unsigned      model_depth;
  logic [CAP_W-1:0] model_cap;

  stack_word_t step_words[$];      // words produced by the latest operation
  stack_word_t expected_words[$];  // words still owed by the block, oldest first
  stack_word_t head_word;

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int items_sent;
  int items_live;
  int results_seen;
  int cap_writes;
  int stall_cycles;

  logic [CAP_W-1:0] cap_plan [RAND_PHASES];

  // Directed script. Capacity rows carry the new capacity in the key field.
  row_t script [SCRIPT_LEN] = '{
    '{KIND_POP,       64'h0,                  ROW_SILENT, 64'h0,                  1'b0},
    '{KIND_PEEK,      64'h0,                  ROW_SILENT, 64'h0,                  1'b0},
    '{KIND_DUMP_TD,   64'h0,                  ROW_SILENT, 64'h0,                  1'b0},
    '{KIND_UNUSED_LO, 64'hFFFF_FFFF_FFFF_FFFF, ROW_SILENT, 64'h0,                 1'b0},
    '{KIND_PUSH,      64'h0,                  ROW_MODEL,  64'h0,                  1'b0},
    '{KIND_PEEK,      64'h0,                  ROW_SINGLE, 64'h0,                  1'b1},
    '{KIND_PUSH,      64'hFFFF_FFFF_FFFF_FFFF, ROW_MODEL, 64'h0,                  1'b0},
    '{KIND_PEEK,      64'h0,                  ROW_SINGLE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1},
    '{KIND_PUSH,      64'hA5A5_5A5A_0F0F_F0F0, ROW_MODEL, 64'h0,                  1'b0},
    '{KIND_DUMP_TD,   64'h0,                  ROW_MODEL,  64'h0,                  1'b0},
    '{KIND_DUMP_BU,   64'h0,                  ROW_MODEL,  64'h0,                  1'b0},
    '{KIND_UNUSED_HI, 64'h1234,               ROW_SILENT, 64'h0,                  1'b0},
    '{KIND_POP,       64'h0,                  ROW_MODEL,  64'h0,                  1'b0},
    '{KIND_PEEK,      64'h0,                  ROW_SINGLE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1},
    '{KIND_POP,       64'h0,                  ROW_MODEL,  64'h0,                  1'b0},
    '{KIND_POP,       64'h0,                  ROW_MODEL,  64'h0,                  1'b0},
    '{KIND_POP,       64'h0,                  ROW_SILENT, 64'h0,                  1'b0},
    '{KIND_PUSH,      64'd1,                  ROW_SETCAP, 64'h0,                  1'b0},
    '{KIND_PUSH,      64'h8000_0000_0000_0001, ROW_MODEL, 64'h0,                  1'b0},
    '{KIND_PUSH,      64'h1234,               ROW_SILENT, 64'h0,                  1'b0},
    '{KIND_DUMP_TD,   64'h0,                  ROW_SINGLE, 64'h8000_0000_0000_0001, 1'b1},
    '{KIND_PUSH,      64'd0,                  ROW_SETCAP, 64'h0,                  1'b0},
    '{KIND_PUSH,      64'h55,                 ROW_SILENT, 64'h0,                  1'b0},
    '{KIND_PEEK,      64'h0,                  ROW_SINGLE, 64'h8000_0000_0000_0001, 1'b1},
    '{KIND_POP,       64'h0,                  ROW_MODEL,  64'h0,                  1'b0},
    '{KIND_PUSH,      64'h66,                 ROW_SILENT, 64'h0,                  1'b0},
    '{KIND_DUMP_BU,   64'h0,                  ROW_SILENT, 64'h0,                  1'b0},
    '{KIND_PUSH,      64'd63,                 ROW_SETCAP, 64'h0,                  1'b0},
    '{KIND_PUSH,      64'h7FFF_FFFF_FFFF_FFFF, ROW_MODEL, 64'h0,                  1'b0},
    '{KIND_DUMP_BU,   64'h0,                  ROW_SINGLE, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1}
  };

  bounded_lifo_stack_with_dump uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_kind   (in_kind),
    .in_key    (in_key),
    .empty     (empty),
    .pop       (pop),
    .out_value (out_value),
    .out_last  (out_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one operation to the predictor; leave the words it reports in
  // step_words. Return 1 when the operation did anything at all.
  function automatic bit stack_model_step(input logic [KIND_W-1:0] kind,
                                          input logic [KEY_W-1:0] key);
    int unsigned limit;
    bit changed;
    limit   = (model_cap > DEPTH_DEF) ? DEPTH_DEF : model_cap;
    changed = 1'b0;
    step_words.delete();
    case (kind)
      KIND_PUSH: begin
        // A lowered capacity keeps stored entries but blocks further pushes.
        if (model_depth < limit) begin
          model_entries[model_depth] = key & KEY_MASK;
          model_depth++;
          changed = 1'b1;
        end
      end
      KIND_POP: begin
        if (model_depth > 0) begin
          model_depth--;
          changed = 1'b1;
        end
      end
      KIND_PEEK: begin
        if (model_depth > 0)
          step_words.push_back(stack_word_t'{model_entries[model_depth-1], 1'b1});
      end
      KIND_DUMP_TD: begin
        for (int i = model_depth; i > 0; i--)
          step_words.push_back(stack_word_t'{model_entries[i-1], i == 1});
      end
      KIND_DUMP_BU: begin
        for (int i = 0; i < model_depth; i++)
          step_words.push_back(stack_word_t'{model_entries[i], i + 1 == model_depth});
      end
      default: ;
    endcase
    return changed || step_words.size() != 0;
  endfunction

  // Filling phases lean on push, draining phases on pop; a few unused codes
  // are mixed in as noise.
  function automatic logic [KIND_W-1:0] pick_kind(input bit filling);
    int unsigned roll;
    int unsigned push_cut;
    int unsigned pop_cut;
    roll     = $urandom_range(99);
    push_cut = filling ? 65 : 25;
    pop_cut  = filling ? 75 : 70;
    if (roll < push_cut) return KIND_PUSH;
    if (roll < pop_cut) return KIND_POP;
    if (roll < pop_cut + 8) return KIND_PEEK;
    if (roll < pop_cut + 15) return KIND_DUMP_TD;
    if (roll < pop_cut + 21) return KIND_DUMP_BU;
    return KIND_W'(KIND_UNUSED_LO + $urandom_range(KIND_UNUSED_HI - KIND_UNUSED_LO));
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_LIMIT)
      $display("%0t mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_RECV_SLOW: begin
        send_idle_pct = 8;
        recv_idle_pct = 46;
      end
      IDLE_SEND_SLOW: begin
        send_idle_pct = 46;
        recv_idle_pct = 8;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // Offer one operation and hold it until the block takes it, then record
  // what the block owes for it.
  task automatic issue_op(input row_t row);
    // first hold push low while random draws fall below send_idle_pct
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_kind <= row.kind;
    in_key  <= row.key;
    do @(posedge clk); while (full);
    items_sent++;
    if (stack_model_step(row.kind, row.key))
      items_live++;
    case (row.tag)
      ROW_MODEL:  foreach (step_words[i]) expected_words.push_back(step_words[i]);
      ROW_SINGLE: expected_words.push_back(stack_word_t'{row.exp_value, row.exp_last});
      default: ;
    endcase
  endtask

  // Write capacity only once the block has gone quiet: every owed word
  // delivered, and time for silent operations still queued to retire.
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    push <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_cap = cap;
    cap_writes++;
  endtask

  // Result side: check each accepted word against the oldest owed word,
  // then decide whether to stall pop for the next cycle.
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      results_seen++;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%h last=%b", out_value, out_last));
      end else begin
        head_word = expected_words.pop_front();
        if (out_value !== head_word.value)
          report_mismatch($sformatf("value %h, want %h", out_value, head_word.value));
        if (out_last !== head_word.last)
          report_mismatch($sformatf("last %b, want %b (value %h)", out_last,
                                    head_word.last, head_word.value));
      end
    end
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: count cycles in which no channel moves a transaction.
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d words still owed",
               stall_cycles, expected_words.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int tries;
    model_depth   = 0;
    model_cap     = CAP_RESET;
    mismatches    = 0;
    items_sent    = 0;
    items_live    = 0;
    results_seen  = 0;
    cap_writes    = 0;
    set_idle(IDLE_RECV_SLOW);

    // Capacity per random phase: extremes, out-of-range values and a few
    // random ones. Zero follows a filling phase so stored entries outlive it.
    cap_plan = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd0, 6'd33, 6'd3, 6'd0, CAP_RESET};
    cap_plan[4] = CAP_W'($urandom_range(2, 31));
    cap_plan[7] = CAP_W'($urandom_range(1, 32));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: walk the script, starting at reset capacity; capacity rows change it.
    foreach (script[r]) begin
      if (script[r].tag == ROW_SETCAP)
        set_capacity(script[r].key[CAP_W-1:0]);
      else
        issue_op(script[r]);
    end

    // Random part: one capacity per phase; idling style changes every
    // three phases.
    for (int p = 0; p < RAND_PHASES; p++) begin
      set_idle(idle_mode_t'(p / 3));
      set_capacity(cap_plan[p]);
      tries = 0;
      while (tries < PHASE_ITEMS) begin
        issue_op(row_t'{pick_kind(p % 2 == 1), pick_key(), ROW_MODEL, '0, 1'b0});
        tries++;
      end
    end

    // Drain: wait out every owed word, then watch for stray results.
    push <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d operations (%0d acted on the stack) over %0d capacity settings;",
             items_sent, items_live, cap_writes);
    $display("checked %0d result words, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
